>>> rtl/core/utd_pkg.sv
// shared types and constants for the utc date to epoch seconds converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package utd_pkg;

  // year field limits, in years since 1900
  localparam logic signed [14:0] YEAR_MAX = 15'sd10000;
  localparam logic signed [14:0] YEAR_MIN = -15'sd10000;

  // year - 1 + 1900 + 8400 keeps the shifted year count non-negative
  localparam logic signed [15:0] YEAR_BIAS  = 16'sd10299;
  // shifted count of the year before the epoch year
  localparam logic signed [15:0] EPOCH_BIAS = 16'sd10369;
  // leap days counted at the epoch plus the bias term of the shifted count
  localparam logic signed [15:0] LEAP_BIAS  = 16'sd2514;

  // reciprocal of 100, scaled by 2^19, exact for counts below 20300
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int          RECIP_SH  = 19;

  localparam int DAYS_W = 24;
  localparam int SECS_W = 40;
  localparam int HMS_W  = 17;

  localparam logic [3:0] MON_FEB = 4'd1;

  typedef struct packed {
    logic        err;
    logic [14:0] n;       // shifted count of the year before
    logic [7:0]  q0;      // n / 100
    logic [3:0]  mon;
    logic [4:0]  mday;
    logic [4:0]  hr;
    logic [5:0]  mins;
    logic [5:0]  sec;
  } utd_item_t;

  // cumulative days before each month, months past december read as december
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      default: d = 9'd334;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/utd_front.sv
// front end: takes input beats, checks the year range, divides the shifted year count by 100
// depends on utd_pkg
`timescale 1ns / 1ps
`default_nettype none

module utd_front
  import utd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [5:0]        second,
  input  wire logic [5:0]        minute,
  input  wire logic [4:0]        hour,
  input  wire logic [4:0]        day_of_month,
  input  wire logic [3:0]        month,
  input  wire logic signed [14:0] years_since_1900,
  output logic                   f_valid,
  input  wire logic              f_stall,
  output utd_item_t              f_item
);

  logic             load;
  logic signed [15:0] n_wide;
  logic [27:0]      prod;
  utd_item_t        item_next;

  assign in_stall = f_valid && f_stall;
  assign load     = !in_stall;

  always_comb begin
    n_wide             = 16'(years_since_1900) + YEAR_BIAS;
    prod               = 28'(n_wide[14:0]) * 28'(RECIP_100);
    item_next.err      = (years_since_1900 > YEAR_MAX) || (years_since_1900 < YEAR_MIN);
    item_next.n        = n_wide[14:0];
    item_next.q0       = prod[RECIP_SH +: 8];
    item_next.mon      = month;
    item_next.mday     = day_of_month;
    item_next.hr       = hour;
    item_next.mins     = minute;
    item_next.sec      = second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (load) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      f_item <= item_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/utd_queue.sv
// two-entry queue between front and back ends
// depends on utd_pkg
`timescale 1ns / 1ps
`default_nettype none

module utd_queue
  import utd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_stall,
  input  wire utd_item_t push_item,
  output logic      pop_valid,
  input  wire logic pop_stall,
  output utd_item_t pop_item
);

  utd_item_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_stall = (count == 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/utd_back.sv
// back end: day count, then seconds, into the output register
// depends on utd_pkg
`timescale 1ns / 1ps
`default_nettype none

module utd_back
  import utd_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     q_valid,
  output logic                          q_stall,
  input  wire utd_item_t                q_item,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [SECS_W-1:0]      epoch_seconds,
  output logic                          out_of_range
);

  // day stage
  logic                     a_valid;
  logic                     a_err;
  logic signed [DAYS_W-1:0] a_days;
  logic [HMS_W-1:0]         a_hms;

  logic                     move;
  logic                     a_load;
  logic [14:0]              y1;
  logic [14:0]              r0;
  logic                     leap;
  logic signed [15:0]       yd;
  logic signed [15:0]       ld;
  logic signed [DAYS_W-1:0] days;
  logic [HMS_W-1:0]         hms;
  logic signed [SECS_W-1:0] secs;

  assign move    = !out_valid || !out_stall;
  assign a_load  = !a_valid || move;
  assign q_stall = !a_load;

  always_comb begin
    y1   = q_item.n + 15'd1;
    r0   = q_item.n - (15'(q_item.q0) * 15'd100);
    // divisible by 4, and not a century unless a multiple of 400
    leap = (y1[1:0] == 2'd0) && ((r0 != 15'd99) || (q_item.q0[1:0] == 2'd3));
    yd   = $signed({1'b0, q_item.n}) - EPOCH_BIAS;
    ld   = $signed(16'(q_item.n[14:2])) - $signed(16'(q_item.q0))
         + $signed(16'(q_item.q0[7:2])) - LEAP_BIAS;
    days = DAYS_W'(yd) * DAYS_W'(365) + DAYS_W'(ld)
         + $signed(DAYS_W'(q_item.mday)) - DAYS_W'(1)
         + $signed(DAYS_W'(days_before(q_item.mon)))
         + $signed(DAYS_W'((q_item.mon > MON_FEB) && leap));
    hms  = HMS_W'(q_item.hr) * HMS_W'(3600) + HMS_W'(q_item.mins) * HMS_W'(60)
         + HMS_W'(q_item.sec);
    secs = SECS_W'(a_days) * SECS_W'(86400) + $signed(SECS_W'(a_hms));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_load) a_valid   <= q_valid;
      if (move)   out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load && q_valid) begin
      a_err  <= q_item.err;
      a_days <= days;
      a_hms  <= hms;
    end
    if (move && a_valid) begin
      out_of_range  <= a_err;
      epoch_seconds <= a_err ? '1 : secs;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/utc_date_to_epoch_seconds.sv
// top level of the utc date to epoch seconds converter
// depends on utd_pkg, utd_front, utd_queue, utd_back
//
// usage
//   input channel: in_valid / in_stall, one broken-down utc date per beat
//   (second, minute, hour, day_of_month, month 0..11, years_since_1900)
//   output channel: out_valid / out_stall, one beat per input beat carrying
//   epoch_seconds (signed seconds since 1970-01-01) and out_of_range
//   a year beyond +/-10000 from 1900 gives out_of_range = 1, epoch_seconds = -1
//   throughput: one beat per cycle, sustained with no stall on the output
//   an accepted beat passes the front register, the queue, the day stage and
//   the output register before out_valid; the front multiply by the
//   reciprocal of 100 and the back multiply by 86400 each take a stage of
//   their own
//   the two-entry queue lets the front keep taking beats while the back waits
//   output stall holds the output register and backs up through the day stage
//   and the queue to in_stall; no beat is dropped or repeated
//   reset (rst, synchronous) empties every stage; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module utc_date_to_epoch_seconds
  import utd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [5:0]           second,
  input  wire logic [5:0]           minute,
  input  wire logic [4:0]           hour,
  input  wire logic [4:0]           day_of_month,
  input  wire logic [3:0]           month,
  input  wire logic signed [14:0]   years_since_1900,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [SECS_W-1:0]  epoch_seconds,
  output logic                      out_of_range
);

  // front to queue
  logic      f_valid;
  logic      f_stall;
  utd_item_t f_item;

  // queue to back
  logic      q_valid;
  logic      q_stall;
  utd_item_t q_item;

  utd_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .second           (second),
    .minute           (minute),
    .hour             (hour),
    .day_of_month     (day_of_month),
    .month            (month),
    .years_since_1900 (years_since_1900),
    .f_valid          (f_valid),
    .f_stall          (f_stall),
    .f_item           (f_item)
  );

  utd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_stall (f_stall),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_stall  (q_stall),
    .pop_item   (q_item)
  );

  utd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_stall       (q_stall),
    .q_item        (q_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .epoch_seconds (epoch_seconds),
    .out_of_range  (out_of_range)
  );

`ifndef ASSERT_OFF
  // an error beat always carries all ones
  a_err_value : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> (&epoch_seconds))
    else $error("out_of_range beat without -1 result");

  // an accepted input beat lands in the front register
  a_front_load : assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> f_valid)
    else $error("accepted beat lost at front");

  // a front beat blocked by a full queue is still there next cycle
  a_front_hold : assert property (@(posedge clk) disable iff (rst)
    f_valid && f_stall |=> f_valid && $stable(f_item))
    else $error("front beat changed while queue full");
`endif

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// self-checking testbench for utc_date_to_epoch_seconds: drives utc dates and
// checks every epoch seconds beat against a timegm-style prediction
// depends on utd_pkg and the rtl of utc_date_to_epoch_seconds
`timescale 1ns / 1ps

module tb_top;

  localparam logic [3:0] MON_JAN = 4'd0;
  localparam logic [3:0] MON_DEC = 4'd11;
  localparam int EPOCH_YEAR  = 1970;
  localparam int BASE_YEAR   = 1900;
  localparam int HOLD_CYCLES = 80;
  localparam int TAIL_CYCLES = 10;
  localparam int RANDOM_BEATS = 310;

  typedef struct {
    logic [5:0]         sec;
    logic [5:0]         mins;
    logic [4:0]         hr;
    logic [4:0]         mday;
    logic [3:0]         mon;
    logic signed [14:0] ys;
  } date_beat_t;

  typedef struct {
    logic signed [utd_pkg::SECS_W-1:0] secs;
    logic                              oor;
  } epoch_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [5:0]         second = '0;
  logic [5:0]         minute = '0;
  logic [4:0]         hour = '0;
  logic [4:0]         day_of_month = 5'd1;
  logic [3:0]         month = MON_JAN;
  logic signed [14:0] years_since_1900 = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [utd_pkg::SECS_W-1:0] epoch_seconds;
  logic               out_of_range;

  // pending epoch values, oldest first
  epoch_beat_t pending_epochs[$];
  int          mismatches = 0;

  // idling switches and the long receiver hold request
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit hold_req   = 1'b0;

  utc_date_to_epoch_seconds dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .second           (second),
    .minute           (minute),
    .hour             (hour),
    .day_of_month     (day_of_month),
    .month            (month),
    .years_since_1900 (years_since_1900),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .epoch_seconds    (epoch_seconds),
    .out_of_range     (out_of_range)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------

  function automatic longint cum_days(input logic [3:0] m);
    case (m)
      4'd0:    return 0;
      4'd1:    return 31;
      4'd2:    return 59;
      4'd3:    return 90;
      4'd4:    return 120;
      4'd5:    return 151;
      4'd6:    return 181;
      4'd7:    return 212;
      4'd8:    return 243;
      4'd9:    return 273;
      4'd10:   return 304;
      default: return 334;
    endcase
  endfunction

  // division rounding toward minus infinity
  function automatic longint div_floor(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  // gregorian leap years in 1..y, extended to negative years
  function automatic longint leaps_through(input longint y);
    return div_floor(y, 4) - div_floor(y, 100) + div_floor(y, 400);
  endfunction

  function automatic bit gregorian_leap(input longint y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic epoch_beat_t predict_epoch(input date_beat_t d);
    epoch_beat_t r;
    logic [3:0]  m;
    longint      yr;
    longint      days;
    longint      t;
    if (d.ys > utd_pkg::YEAR_MAX || d.ys < utd_pkg::YEAR_MIN) begin
      r.secs = '1;
      r.oor  = 1'b1;
      return r;
    end
    // month codes past december count as december
    m    = (d.mon > MON_DEC) ? MON_DEC : d.mon;
    yr   = longint'(d.ys) + BASE_YEAR;
    days = longint'(d.mday) - 1 + cum_days(m);
    if (m > utd_pkg::MON_FEB && gregorian_leap(yr)) days = days + 1;
    days = days + 365 * (yr - EPOCH_YEAR)
         + leaps_through(yr - 1) - leaps_through(EPOCH_YEAR - 1);
    t = longint'(d.sec) + longint'(d.mins) * 60 + longint'(d.hr) * 3600
      + days * 86400;
    r.secs = t[utd_pkg::SECS_W-1:0];
    r.oor  = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(input bit en);
    int r;
    if (!en) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 19) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic date_beat_t make_date(input int s, input int mi, input int h,
                                           input int dm, input int mo, input int y);
    date_beat_t d;
    d.sec  = s[5:0];
    d.mins = mi[5:0];
    d.hr   = h[4:0];
    d.mday = dm[4:0];
    d.mon  = mo[3:0];
    d.ys   = y[14:0];
    return d;
  endfunction

  function automatic date_beat_t random_date();
    int r;
    int y;
    r = $urandom_range(0, 19);
    if (r == 0) y = $urandom_range(0, 32767);                         // any code
    else if (r == 1) y = 10000 + $urandom_range(0, 4) - 2;            // upper edge
    else if (r == 2) y = -10000 + $urandom_range(0, 4) - 2;           // lower edge
    else if (r < 6) y = $urandom_range(0, 200);                       // 1900..2100
    else y = int'($urandom_range(0, 20000)) - 10000;
    // each field mostly legal, sometimes any value its width allows
    return make_date(
      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 60),
      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59),
      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 23),
      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 31),
      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 11),
      y);
  endfunction

  // offers one date beat and waits until it is taken
  task automatic send_date(input date_beat_t d);
    int gap;
    gap = pick_gap(tx_idle_en);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    second           <= d.sec;
    minute           <= d.mins;
    hour             <= d.hr;
    day_of_month     <= d.mday;
    month            <= d.mon;
    years_since_1900 <= d.ys;
    do @(posedge clk); while (in_stall);
    pending_epochs.push_back(predict_epoch(d));
  endtask

  // stop offering, then wait for every outstanding result
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_epochs.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // field extremes, year limits, leap rules and month saturation
  task automatic test_directed();
    int years[8];
    int k;
    years = '{100, 0, -1900, 200, 70, -1901, 8100, 104};
    send_date(make_date(0, 0, 0, 1, 0, 70));        // the epoch itself
    send_date(make_date(63, 63, 31, 31, 15, 10000)); // all date fields at width max, highest legal year
    send_date(make_date(0, 0, 0, 0, 0, -10000));    // day 0, lowest legal year
    send_date(make_date(60, 59, 23, 31, 11, 9999)); // leap second
    send_date(make_date(5, 5, 5, 5, 5, 10001));     // just past the upper limit
    send_date(make_date(5, 5, 5, 5, 5, -10001));    // just past the lower limit
    send_date(make_date(63, 63, 31, 31, 15, 16383));
    send_date(make_date(0, 0, 0, 0, 0, -16384));
    // every month code, twelve through fifteen saturating to december,
    // across leap and common years, year zero and negative years
    for (k = 0; k < 16; k++)
      send_date(make_date(k * 4, 59 - k, k, (k == 3) ? 0 : 31 - k, k, years[k % 8]));
    wait_drained();
  endtask

  task automatic test_random(input int count);
    int k;
    for (k = 0; k < count; k++) send_date(random_date());
    wait_drained();
  endtask

  // both sides run flat out
  task automatic test_back_to_back();
    int k;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (k = 0; k < 30; k++) send_date(random_date());
    wait_drained();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // receiver holds off long enough for the pipe to fill and back up
  task automatic test_backpressure();
    int k;
    tx_idle_en = 1'b0;
    hold_req   = 1'b1;
    for (k = 0; k < 40; k++) send_date(random_date());
    wait_drained();
    tx_idle_en = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // receiver side: random stall stretches, or a counted long hold
  // ---------------------------------------------------------------------
  initial begin : rx_side
    int run;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!rx_idle_en || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
        run = $urandom_range(1, 12);
        repeat (run) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        run = pick_gap(1'b1);
        if (run == 0) run = 1;
        repeat (run) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------
  // result checking, one output beat at a time against the oldest prediction
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    epoch_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_epochs.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat: epoch_seconds %0d out_of_range %0b",
                 $time, epoch_seconds, out_of_range);
      end else begin
        want = pending_epochs.pop_front();
        if (epoch_seconds !== want.secs) begin
          mismatches++;
          $display("%0t: epoch_seconds expected %0d actual %0d",
                   $time, want.secs, epoch_seconds);
        end
        if (out_of_range !== want.oor) begin
          mismatches++;
          $display("%0t: out_of_range expected %0b actual %0b",
                   $time, want.oor, out_of_range);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // sequence of tests
  // ---------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(RANDOM_BEATS);
    test_back_to_back();
    test_backpressure();
    in_valid <= 1'b0;
    wait_drained();
    // let any stray beat surface before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("%0t: run limit reached", $time);
    $display("tb_top: errors");
    $finish;
  end

endmodule
